[src/obs_pkg.sv]
package obs_pkg;

	localparam int unsigned LEVEL_W   = 16;
	localparam int unsigned SUM_W     = 24;
	localparam int unsigned CNT_W     = 8;
	localparam int unsigned FADE_W    = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 8;
	localparam int unsigned DIV_STEPS = SUM_W;
	localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

	localparam int unsigned HOLD_SAMPLES_DEF = 10000;
	localparam logic [CNT_W-1:0] CPS_RESET = CNT_W'(23);

	localparam logic signed [LEVEL_W-1:0] DRIVE_LOUD  = 16'sh8000;
	localparam logic signed [LEVEL_W-1:0] DRIVE_QUIET = -16'sd8192;
	localparam logic signed [LEVEL_W-1:0] LEVEL_INIT  = 16'sh8000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLKS_PER_SAMPLE = 2'd0,
		REG_QUIETER         = 2'd1,
		REG_FULL_SPEED      = 2'd2
	} obs_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_FIN
	} obs_state_t;

	typedef struct packed {
		logic take;
		logic div_step;
		logic mul;
		logic fin;
	} obs_cmd_t;

	typedef struct packed {
		logic emit;
		logic div_last;
		logic out_free;
	} obs_sts_t;

endpackage

[src/obs_ifs.sv]
interface obs_item_if;
	logic valid;
	logic ready;
	logic toggle;
	modport source (output valid, output toggle, input ready);
	modport sink   (input valid, input toggle, output ready);
endinterface

interface obs_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;
	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface obs_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[src/obs_ctrl.sv]
module obs_ctrl
	import obs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  obs_sts_t sts,
	output obs_cmd_t cmd
);

	obs_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				cmd.take   = item_valid;
				if (item_valid && sts.emit) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				// hold until the output register can take the word
				if (sts.out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[src/obs_dp.sv]
module obs_dp
	import obs_pkg::*;
#(
	parameter int unsigned HOLD_SAMPLES = HOLD_SAMPLES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DAT_W-1:0]        cfg_data,
	input  logic                        toggle,
	input  obs_cmd_t                    cmd,
	output obs_sts_t                    sts,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [LEVEL_W-1:0]   sample
);

	localparam logic [FADE_W-1:0] FADE_RELOAD = FADE_W'(32768 + HOLD_SAMPLES);

	logic [CNT_W-1:0]          cps_q;
	logic                      quiet_q;
	logic                      fs_q;
	logic signed [LEVEL_W-1:0] level_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [FADE_W-1:0]         fade_q;
	logic                      tog_q;

	logic                      neg_q;
	logic [CNT_W:0]            rem_q;
	logic [CNT_W:0]            dvs_q;
	logic [SUM_W-1:0]          quo_q;
	logic [STEP_W-1:0]         step_q;

	logic signed [LEVEL_W-1:0]   mean_q;
	logic signed [2*LEVEL_W-1:0] prod_q;

	logic                      out_valid_q;
	logic signed [LEVEL_W-1:0] sample_q;

	logic signed [SUM_W-1:0]   new_sum;
	logic [CNT_W-1:0]          new_cnt;
	logic                      emit;
	logic [SUM_W-1:0]          sum_mag;
	logic [CNT_W+1:0]          rem_sh;
	logic                      ge;
	logic [CNT_W+1:0]          rem_sub;
	logic [LEVEL_W:0]          quo_lo;
	logic signed [LEVEL_W-1:0] mean_c;
	logic signed [2*LEVEL_W-1:0] prod_rnd;
	logic signed [LEVEL_W-1:0] faded;
	logic signed [LEVEL_W-1:0] drive;
	logic                      tog_now;
	logic                      tog_apply;

	assign new_sum = sum_q + SUM_W'(level_q);
	assign new_cnt = cnt_q + CNT_W'(1);
	// a wrapped count means the CNT_W-bit word counter overflowed
	assign emit    = (new_cnt == '0) || (new_cnt >= cps_q);
	assign sum_mag = new_sum[SUM_W-1] ? SUM_W'(-new_sum) : SUM_W'(new_sum);

	assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	assign quo_lo  = quo_q[LEVEL_W:0];
	assign mean_c  = neg_q ? LEVEL_W'(-quo_lo) : LEVEL_W'(quo_lo);

	// truncate toward zero on the divide by 32768
	assign prod_rnd = prod_q + (prod_q[2*LEVEL_W-1] ? 32'sd32767 : 32'sd0);

	always_comb begin
		if (fade_q == '0) begin
			faded = '0;
		end else if (fade_q[FADE_W-1]) begin
			faded = mean_q;
		end else begin
			faded = prod_rnd[LEVEL_W+14:15];
		end
	end

	assign drive     = quiet_q ? DRIVE_QUIET : DRIVE_LOUD;
	assign tog_now   = cmd.take && !emit && toggle;
	assign tog_apply = tog_now || (cmd.fin && tog_q);

	assign sts.emit     = emit;
	assign sts.div_last = step_q == STEP_W'(DIV_STEPS - 1);
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cps_q       <= CPS_RESET;
			quiet_q     <= 1'b0;
			fs_q        <= 1'b0;
			level_q     <= LEVEL_INIT;
			sum_q       <= '0;
			cnt_q       <= '0;
			fade_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_CLKS_PER_SAMPLE: cps_q   <= cfg_data;
					REG_QUIETER:         quiet_q <= cfg_data[0];
					REG_FULL_SPEED:      fs_q    <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.take) begin
				if (emit) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= new_sum;
					cnt_q <= new_cnt;
				end
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
				if (fade_q != '0) begin
					fade_q <= fade_q - FADE_W'(1);
				end
			end
			// a toggle lands after the sample has used the fade counter
			if (tog_apply) begin
				if (!fs_q) begin
					fade_q <= FADE_RELOAD;
				end
				if (level_q == drive) begin
					level_q <= ~drive;
				end else begin
					level_q <= drive;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			tog_q  <= toggle;
			neg_q  <= new_sum[SUM_W-1];
			rem_q  <= '0;
			quo_q  <= sum_mag;
			dvs_q  <= {new_cnt == '0, new_cnt};
			step_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= ge ? rem_sub[CNT_W:0] : rem_sh[CNT_W:0];
			quo_q  <= {quo_q[SUM_W-2:0], ge};
			step_q <= step_q + STEP_W'(1);
		end
		if (cmd.mul) begin
			mean_q <= mean_c;
			prod_q <= mean_c * $signed({1'b0, fade_q[FADE_W-2:0]});
		end
		if (cmd.fin) begin
			sample_q <= faded;
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;

endmodule

[src/one_bit_speaker_to_pcm_top.sv]
// One-bit speaker to PCM converter.
// item channel: one word per emulated CPU cycle; toggle set when the speaker
// was flipped at the end of that cycle.
// result channel: a signed 16-bit PCM word after every clks_per_sample
// cycles, the truncated mean level passed through a DC fade.
// cfg channel: always ready; index 0 clks_per_sample, 1 quieter,
// 2 full_speed, other indexes ignored. Write only while idle.
// Timing: a cycle word that closes no sample is summed and the block stays
// idle for the next word. One that closes a sample is summed, then passes
// the bit-serial divider and the fade multiply; the load of the output
// register waits for it to empty, and the result is registered there.
// The output register holds a finished word, so the next cycle words are
// taken while the receiver stalls; only a word that closes another sample
// waits for the register to empty.
// Reset: level -32768, sum, count and fade counter cleared, registers to
// defaults (23, 0, 0), output empty.
module one_bit_speaker_to_pcm_top
	import obs_pkg::*;
#(
	parameter int unsigned HOLD_SAMPLES = HOLD_SAMPLES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	obs_item_if.sink     item,
	obs_sample_if.source result,
	obs_cfg_if.sink      cfg
);

	obs_cmd_t cmd;
	obs_sts_t sts;

	assign cfg.ready = 1'b1;

	obs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	obs_dp #(
		.HOLD_SAMPLES (HOLD_SAMPLES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.toggle    (item.toggle),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sample    (result.sample)
	);

endmodule
